/* design/grib1_message_header_parser_assert.svh */
// Assertion macros shared by the parser RTL.
`ifndef GRIB1_MESSAGE_HEADER_PARSER_ASSERT_SVH
`define GRIB1_MESSAGE_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define G1HDR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define G1HDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/g1hdr_pkg.sv */
package g1hdr_pkg;

    localparam int LEN_BITS = 24;

    typedef logic [LEN_BITS-1:0] t_len;

    typedef enum logic [6:0] {
        PH_SEARCH = 7'b0000001,
        PH_SEC0   = 7'b0000010,
        PH_SEC1   = 7'b0000100,
        PH_SEC2   = 7'b0001000,
        PH_SEC3   = 7'b0010000,
        PH_SEC4   = 7'b0100000,
        PH_END    = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_END = 2'd1,
        ST_SHORT   = 2'd2
    } t_status;

    localparam logic [23:0] MARKER_HEAD = 24'h475249; // "GRI"
    localparam logic [7:0]  CH_B        = 8'h42;
    localparam logic [7:0]  CH_SEVEN    = 8'h37;
    localparam logic [7:0]  FLAG_GDS    = 8'h80;
    localparam logic [7:0]  FLAG_BMS    = 8'h40;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [23:0] total_length;
        logic [7:0]  edition;
        logic [7:0]  center;
        logic [7:0]  parameter_code;
        logic [7:0]  flags;
        logic [15:0] grid_columns;
        logic [15:0] grid_rows;
        logic        bitmap_present;
        logic [7:0]  bits_per_value;
        logic [15:0] binary_scale_raw;
        logic [31:0] reference_raw;
    } t_hdr;

    typedef struct packed {
        t_status     status;
        logic [31:0] message_number;
        t_hdr        hdr;
    } t_result;

endpackage

/* design/g1hdr_walker.sv */
module g1hdr_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_data_byte,
    output logic               o_emit,
    output logic               o_may_emit,
    output g1hdr_pkg::t_result o_result
);
    import g1hdr_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [23:0] r_window, n_window;
    t_len        r_idx,    n_idx;
    t_len        r_len,    n_len;
    logic        r_bad,    n_bad;
    logic [31:0] r_count,  n_count;
    t_hdr        r_hdr,    n_hdr;

    t_len    w_idx_inc;
    t_len    w_len_shift;
    logic    w_advance;
    t_status w_status;

    function automatic t_phase next_phase(input t_phase ph, input logic [7:0] flags);
        t_phase nxt;
        nxt = PH_END;
        if (ph == PH_SEC1) begin
            if ((flags & FLAG_GDS) != 8'h00) nxt = PH_SEC2;
            else if ((flags & FLAG_BMS) != 8'h00) nxt = PH_SEC3;
            else nxt = PH_SEC4;
        end else if (ph == PH_SEC2) begin
            nxt = ((flags & FLAG_BMS) != 8'h00) ? PH_SEC3 : PH_SEC4;
        end else if (ph == PH_SEC3) begin
            nxt = PH_SEC4;
        end
        return nxt;
    endfunction

    assign w_idx_inc   = r_idx + t_len'(1);
    assign w_len_shift = {r_len[LEN_BITS-9:0], i_data_byte};

    always_comb begin
        n_phase   = r_phase;
        n_window  = r_window;
        n_idx     = r_idx;
        n_len     = r_len;
        n_bad     = r_bad;
        n_count   = r_count;
        n_hdr     = r_hdr;
        w_advance = 1'b0;
        w_status  = ST_GOOD;
        o_emit    = 1'b0;
        if (i_step) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (r_window == MARKER_HEAD && i_data_byte == CH_B) begin
                        if (r_count != COUNT_MAX) n_count = r_count + 32'd1;
                        n_hdr    = '0;
                        n_window = '0;
                        n_phase  = PH_SEC0;
                        n_idx    = t_len'(4);
                    end else begin
                        n_window = {r_window[15:0], i_data_byte};
                    end
                end
                PH_SEC0: begin
                    priority if (r_idx == t_len'(4)) n_hdr.total_length[23:16] = i_data_byte;
                    else if (r_idx == t_len'(5)) n_hdr.total_length[15:8] = i_data_byte;
                    else if (r_idx == t_len'(6)) n_hdr.total_length[7:0] = i_data_byte;
                    else n_hdr.edition = i_data_byte;
                    if (r_idx == t_len'(7)) begin
                        n_phase = PH_SEC1;
                        n_idx   = '0;
                        n_len   = '0;
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end
                PH_SEC1, PH_SEC2, PH_SEC3, PH_SEC4: begin
                    if (r_idx < t_len'(3)) begin
                        n_len = w_len_shift;
                        n_idx = w_idx_inc;
                        if (r_idx == t_len'(2)) begin
                            if (w_len_shift < t_len'(3)) begin
                                o_emit   = 1'b1;
                                w_status = ST_SHORT;
                                n_phase  = PH_SEARCH;
                                n_idx    = '0;
                                n_len    = '0;
                            end else if (w_len_shift == t_len'(3)) begin
                                w_advance = 1'b1;
                            end
                        end
                    end else begin
                        if (r_phase == PH_SEC1) begin
                            if (r_idx == t_len'(4)) n_hdr.center = i_data_byte;
                            if (r_idx == t_len'(7)) n_hdr.flags = i_data_byte;
                            if (r_idx == t_len'(8)) n_hdr.parameter_code = i_data_byte;
                        end else if (r_phase == PH_SEC2) begin
                            if (r_idx == t_len'(6)) n_hdr.grid_columns[15:8] = i_data_byte;
                            if (r_idx == t_len'(7)) n_hdr.grid_columns[7:0] = i_data_byte;
                            if (r_idx == t_len'(8)) n_hdr.grid_rows[15:8] = i_data_byte;
                            if (r_idx == t_len'(9)) n_hdr.grid_rows[7:0] = i_data_byte;
                        end else if (r_phase == PH_SEC3) begin
                            if (r_idx == t_len'(3))
                                n_hdr.bitmap_present = (i_data_byte == 8'h00);
                        end else begin
                            if (r_idx == t_len'(4)) n_hdr.binary_scale_raw[15:8] = i_data_byte;
                            if (r_idx == t_len'(5)) n_hdr.binary_scale_raw[7:0] = i_data_byte;
                            if (r_idx == t_len'(6)) n_hdr.reference_raw[31:24] = i_data_byte;
                            if (r_idx == t_len'(7)) n_hdr.reference_raw[23:16] = i_data_byte;
                            if (r_idx == t_len'(8)) n_hdr.reference_raw[15:8] = i_data_byte;
                            if (r_idx == t_len'(9)) n_hdr.reference_raw[7:0] = i_data_byte;
                            if (r_idx == t_len'(10)) n_hdr.bits_per_value = i_data_byte;
                        end
                        n_idx = w_idx_inc;
                        if (w_idx_inc == r_len) w_advance = 1'b1;
                    end
                end
                PH_END: begin
                    n_bad = r_bad | (i_data_byte != CH_SEVEN);
                    n_idx = w_idx_inc;
                    if (r_idx == t_len'(3)) begin
                        o_emit   = 1'b1;
                        w_status = n_bad ? ST_BAD_END : ST_GOOD;
                        n_phase  = PH_SEARCH;
                        n_idx    = '0;
                        n_bad    = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_SEARCH;
                    n_idx   = '0;
                    n_len   = '0;
                end
            endcase
            if (w_advance) begin
                // flags may have been captured on this very beat
                n_phase = next_phase(r_phase, n_hdr.flags);
                n_idx   = '0;
                n_len   = '0;
                n_bad   = 1'b0;
                if (n_phase == PH_SEC3) n_hdr.bitmap_present = 1'b1;
            end
        end
    end

    assign o_may_emit = ((r_phase == PH_END) && (r_idx == t_len'(3)))
                     || (((r_phase == PH_SEC1) || (r_phase == PH_SEC2)
                       || (r_phase == PH_SEC3) || (r_phase == PH_SEC4))
                       && (r_idx == t_len'(2)));

    always_comb begin
        o_result.status         = w_status;
        o_result.message_number = r_count;
        o_result.hdr            = r_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEARCH;
            r_window <= '0;
            r_idx    <= '0;
            r_len    <= '0;
            r_bad    <= 1'b0;
            r_count  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_idx    <= n_idx;
            r_len    <= n_len;
            r_bad    <= n_bad;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

/* design/grib1_message_header_parser.sv */
// GRIB edition 1 message header parser.
// Input channel: one stream byte per beat on i_data_byte (i_in_valid/o_in_ready).
// Output channel: one header record per message on the o_* field ports
// (o_out_valid/i_out_ready), sent on the fourth end-marker byte with status
// good or bad end marker, or on the third length byte of a section whose
// length is below 3. After either, the block searches for "GRIB" again.
// Throughput: one byte per cycle while o_in_ready is high. Each byte is
// handled in the cycle it is accepted; a record is visible on the output in
// the cycle after the byte that completes it, and the output register holds
// it until taken. While a record waits, bytes keep being accepted; only a
// byte that could complete the next record is held off until the output
// register frees up. Records are at least eleven bytes apart, so a short
// stall of the receiver does not slow the input.
// Reset (synchronous, active low) returns to the marker search with an empty
// window, clears the message counter and drops any pending record.
`include "grib1_message_header_parser_assert.svh"

module grib1_message_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_message_number,
    output logic [23:0] o_total_length,
    output logic [7:0]  o_edition,
    output logic [7:0]  o_center,
    output logic [7:0]  o_parameter_code,
    output logic [15:0] o_grid_columns,
    output logic [15:0] o_grid_rows,
    output logic        o_bitmap_present,
    output logic [7:0]  o_bits_per_value,
    output logic [15:0] o_binary_scale_raw,
    output logic [31:0] o_reference_raw
);
    import g1hdr_pkg::*;

    logic    w_in_accept;
    logic    w_out_accept;
    logic    w_emit;
    logic    w_may_emit;
    t_result w_result;

    logic    r_out_valid;
    t_result r_out;

    g1hdr_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_in_accept),
        .i_data_byte (i_data_byte),
        .o_emit      (w_emit),
        .o_may_emit  (w_may_emit),
        .o_result    (w_result)
    );

    assign o_in_ready   = !w_may_emit || !r_out_valid || i_out_ready;
    assign w_in_accept  = i_in_valid && o_in_ready;
    assign w_out_accept = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_message_number   = r_out.message_number;
    assign o_total_length     = r_out.hdr.total_length;
    assign o_edition          = r_out.hdr.edition;
    assign o_center           = r_out.hdr.center;
    assign o_parameter_code   = r_out.hdr.parameter_code;
    assign o_grid_columns     = r_out.hdr.grid_columns;
    assign o_grid_rows        = r_out.hdr.grid_rows;
    assign o_bitmap_present   = r_out.hdr.bitmap_present;
    assign o_bits_per_value   = r_out.hdr.bits_per_value;
    assign o_binary_scale_raw = r_out.hdr.binary_scale_raw;
    assign o_reference_raw    = r_out.hdr.reference_raw;

    `G1HDR_ASSERT_NOW(a_emit_expected, w_emit, w_may_emit && w_in_accept, "stray record")
    `G1HDR_ASSERT_NOW(a_no_overwrite, w_emit, !r_out_valid || i_out_ready, "record overwritten")
    `G1HDR_ASSERT_NEXT(a_emit_shows, w_emit, o_out_valid, "record not presented after completion")

endmodule
